// ----- rtl/fcr_pkg.sv -----
// shared types and constants of the framed command receiver
`timescale 1ns / 1ps

package fcr_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int RSP_DATA_W  = 56;

   localparam logic [7:0] START_BYTE    = 8'hAA;
   localparam logic [7:0] INTF_INTERNAL = 8'h69;
   localparam logic [7:0] INTF_KEYBOARD = 8'h4B;
   localparam logic [7:0] INTF_MIDI     = 8'h4D;
   localparam logic [7:0] CMD_PING      = 8'h3F;
   localparam logic [7:0] CMD_PONG      = 8'h21;
   localparam logic [7:0] CMD_PRESS     = 8'h50;
   localparam logic [7:0] CMD_RELEASE   = 8'h52;

   localparam logic [2:0] PONG_LAST_BEAT = 3'd4;

   typedef enum logic [1:0] {
      KIND_SERIAL   = 2'd0,
      KIND_MIDI     = 2'd1,
      KIND_KEYBOARD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_PING    = 2'd0,
      OP_MIDI    = 2'd1,
      OP_PRESS   = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] command;
      logic [7:0] first_data;
      logic [7:0] second_data;
   } entry_type;

endpackage

// ----- rtl/framed_command_receiver.sv -----
// top level of the framed command receiver
//
// req channel: one serial byte per request. the receiver hunts for 0xAA, then
// takes interface, command, data1 and data2; the data2 byte dispatches the frame.
// rsp channel: results, kind in rsp_tuser, rsp_tlast on the final result of a
// frame. a ping gives five serial reply bytes, a midi frame one event, a
// keyboard press or release one report; other frames give nothing.
// with the back end idle the first result of a frame passes through the queue,
// written at the edge that accepts its data2 byte, and then through the output
// register, which raises rsp_tvalid.
// throughput: one byte per cycle in, one result per cycle out, while each ready
// is high; a pong's five results are absorbed by the four-entry queue.
// stall: when rsp_tready is low the output register holds; when the queue is
// full req_tready drops only while the receiver waits for a data2 byte.
// reset: synchronous, returns to hunting with empty queue and cleared key state.
`timescale 1ns / 1ps

module framed_command_receiver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // serial_byte, midi_code_index, midi_status, midi_data_a, midi_data_b,
   // key_code, key_modifiers, zero pad
   output logic [fcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // kind
   output logic                           rsp_tlast
);
   import fcr_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      full;
   logic      empty;

   fcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   fcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   fcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- rtl/fcr_front.sv -----
// frame assembly and classification of incoming serial bytes
`timescale 1ns / 1ps

module fcr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               queue_full,
   output logic               push,
   output fcr_pkg::entry_type push_entry
);
   import fcr_pkg::*;

   typedef enum logic [2:0] {
      POS_HUNT  = 3'd0,
      POS_INTF  = 3'd1,
      POS_CMD   = 3'd2,
      POS_DATA1 = 3'd3,
      POS_DATA2 = 3'd4
   } pos_type;

   pos_type    pos_ff, pos_in;
   logic [7:0] intf_ff, intf_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] data1_ff, data1_in;
   logic       accept;
   logic       op_ok;
   op_type     op;

   assign req_tready = !(pos_ff == POS_DATA2 && queue_full);
   assign accept     = req_tvalid && req_tready;

   // classify the frame from interface and command
   always_comb begin
      op    = OP_MIDI;
      op_ok = 1'b0;
      if (intf_ff == INTF_INTERNAL && cmd_ff == CMD_PING) begin
         op    = OP_PING;
         op_ok = 1'b1;
      end else if (intf_ff == INTF_MIDI) begin
         op    = OP_MIDI;
         op_ok = 1'b1;
      end else if (intf_ff == INTF_KEYBOARD && cmd_ff == CMD_PRESS) begin
         op    = OP_PRESS;
         op_ok = 1'b1;
      end else if (intf_ff == INTF_KEYBOARD && cmd_ff == CMD_RELEASE) begin
         op    = OP_RELEASE;
         op_ok = 1'b1;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      intf_in  = intf_ff;
      cmd_in   = cmd_ff;
      data1_in = data1_ff;
      push     = 1'b0;
      if (accept) begin
         case (pos_ff)
            POS_HUNT: begin
               if (req_tdata == START_BYTE) begin
                  pos_in = POS_INTF;
               end
            end
            POS_INTF: begin
               intf_in = req_tdata;
               pos_in  = POS_CMD;
            end
            POS_CMD: begin
               cmd_in = req_tdata;
               pos_in = POS_DATA1;
            end
            POS_DATA1: begin
               data1_in = req_tdata;
               pos_in   = POS_DATA2;
            end
            POS_DATA2: begin
               pos_in = POS_HUNT;
               push   = op_ok;
            end
            default: begin
               pos_in = POS_HUNT;
            end
         endcase
      end
   end

   assign push_entry.op          = op;
   assign push_entry.command     = cmd_ff;
   assign push_entry.first_data  = data1_ff;
   assign push_entry.second_data = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         intf_ff  <= 8'd0;
         cmd_ff   <= 8'd0;
         data1_ff <= 8'd0;
      end else begin
         pos_ff   <= pos_in;
         intf_ff  <= intf_in;
         cmd_ff   <= cmd_in;
         data1_ff <= data1_in;
      end
   end

endmodule

// ----- rtl/fcr_queue.sv -----
// short queue of dispatched frames between front and back
`timescale 1ns / 1ps

module fcr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fcr_pkg::entry_type push_entry,
   input  logic               pop,
   output fcr_pkg::entry_type head,
   output logic               full,
   output logic               empty
);
   import fcr_pkg::*;

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance");

endmodule

// ----- rtl/fcr_back.sv -----
// frame execution: pong replies, midi events and keyboard reports
`timescale 1ns / 1ps

module fcr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  fcr_pkg::entry_type                 head,
   input  logic                               queue_empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fcr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import fcr_pkg::*;

   logic [2:0]            beat_ff, beat_in;
   logic [7:0]            key_ff, key_in;
   logic [7:0]            mods_ff, mods_in;
   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   kind_type              kind_ff, kind_in;
   logic                  last_ff, last_in;
   logic                  fire;
   logic                  beat_done;
   logic [7:0]            serial;

   assign fire      = !queue_empty && (!valid_ff || rsp_tready);
   assign beat_done = (head.op != OP_PING) || (beat_ff == PONG_LAST_BEAT);
   assign pop       = fire && beat_done;

   always_comb begin
      case (beat_ff)
         3'd0:    serial = START_BYTE;
         3'd1:    serial = INTF_INTERNAL;
         3'd2:    serial = CMD_PONG;
         3'd3:    serial = head.first_data;
         default: serial = head.second_data;
      endcase
   end

   always_comb begin
      beat_in  = beat_ff;
      key_in   = key_ff;
      mods_in  = mods_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         data_in  = '0;
         last_in  = 1'b1;
         case (head.op)
            OP_PING: begin
               kind_in      = KIND_SERIAL;
               data_in[7:0] = serial;
               last_in      = beat_done;
               beat_in      = beat_done ? 3'd0 : beat_ff + 3'd1;
            end
            OP_MIDI: begin
               kind_in        = KIND_MIDI;
               data_in[11:8]  = head.command[7:4];
               data_in[19:12] = head.command;
               data_in[27:20] = head.first_data;
               data_in[35:28] = head.second_data;
            end
            OP_PRESS: begin
               kind_in        = KIND_KEYBOARD;
               key_in         = head.first_data;
               mods_in        = head.second_data;
               data_in[43:36] = head.first_data;
               data_in[51:44] = head.second_data;
            end
            default: begin
               kind_in        = KIND_KEYBOARD;
               key_in         = 8'd0;
               mods_in        = head.second_data;
               data_in[51:44] = head.second_data;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 3'd0;
         key_ff   <= 8'd0;
         mods_ff  <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         key_ff   <= key_in;
         mods_ff  <= mods_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   a_beat_in_pong: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != 3'd0) |-> (!queue_empty && head.op == OP_PING))
      else $error("pong beat without a ping at the queue head");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_SERIAL) |-> last_ff)
      else $error("midi or keyboard result without last");

endmodule
